### rtl/u8sd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int CpW = 21;
  localparam logic [CpW-1:0] ReplacementCp = 21'h00FFFD;

  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  // results caused by one byte: n_rep replacement chars, then an optional tail
  typedef struct packed {
    logic [1:0]     n_rep;
    logic           tail_valid;
    logic [CpW-1:0] tail_cp;
  } run_t;

endpackage

### rtl/u8sd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_front
// Takes one byte per transfer, tracks the open sequence and builds the run
// of results that the byte causes.
// ----------------------------------------------------------------------------
module u8sd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  output logic                push,
  output u8sd_pkg::run_t      push_run
);
  import u8sd_pkg::*;

  logic [1:0]     lead_length;
  logic [1:0]     bytes_still_needed;
  logic [CpW-1:0] partial_value;

  logic [1:0]     lead_length_next;
  logic [1:0]     bytes_still_needed_next;
  logic [CpW-1:0] partial_value_next;
  run_t           run;

  logic           is_cont;
  logic [1:0]     need_dec;
  logic [1:0]     taken;
  logic [CpW-1:0] shifted;

  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign need_dec = bytes_still_needed - 2'd1;
  assign taken    = (lead_length >= bytes_still_needed) ?
                    (lead_length - bytes_still_needed) : 2'd0;
  assign shifted  = {partial_value[CpW-7:0], in_byte[5:0]};

  always_comb begin
    lead_length_next        = lead_length;
    bytes_still_needed_next = bytes_still_needed;
    partial_value_next      = partial_value;
    run.n_rep      = 2'd0;
    run.tail_valid = 1'b0;
    run.tail_cp    = ReplacementCp;

    if ((lead_length != 2'd0) && is_cont) begin
      partial_value_next      = shifted;
      bytes_still_needed_next = need_dec;
      if (need_dec == 2'd0) begin
        run.tail_valid          = 1'b1;
        run.tail_cp             = shifted;
        lead_length_next        = 2'd0;
        partial_value_next      = '0;
      end
    end else begin
      // interrupted sequence: one replacement for the lead and each taken byte
      if (lead_length != 2'd0) begin
        run.n_rep = (taken >= 2'd2) ? 2'd3 : (taken + 2'd1);
      end
      lead_length_next        = 2'd0;
      bytes_still_needed_next = 2'd0;
      partial_value_next      = '0;
      if (in_byte[7] == 1'b0) begin
        run.tail_valid = 1'b1;
        run.tail_cp    = {{(CpW-8){1'b0}}, in_byte};
      end else if (in_byte[7:5] == 3'b110) begin
        lead_length_next        = 2'd1;
        bytes_still_needed_next = 2'd1;
        partial_value_next      = {{(CpW-5){1'b0}}, in_byte[4:0]};
      end else if (in_byte[7:4] == 4'b1110) begin
        lead_length_next        = 2'd2;
        bytes_still_needed_next = 2'd2;
        partial_value_next      = {{(CpW-4){1'b0}}, in_byte[3:0]};
      end else if (in_byte[7:3] == 5'b11110) begin
        lead_length_next        = 2'd3;
        bytes_still_needed_next = 2'd3;
        partial_value_next      = {{(CpW-3){1'b0}}, in_byte[2:0]};
      end else begin
        run.tail_valid = 1'b1;
        run.tail_cp    = ReplacementCp;
      end
    end
  end

  assign push     = accept && ((run.n_rep != 2'd0) || run.tail_valid);
  assign push_run = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_length        <= 2'd0;
      bytes_still_needed <= 2'd0;
      partial_value      <= '0;
    end else if (accept) begin
      lead_length        <= lead_length_next;
      bytes_still_needed <= bytes_still_needed_next;
      partial_value      <= partial_value_next;
    end
  end

endmodule

### rtl/u8sd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_queue
// Short register FIFO of result runs between the front and the back.
// ----------------------------------------------------------------------------
module u8sd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  u8sd_pkg::run_t      push_run,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output u8sd_pkg::run_t      head_run
);
  import u8sd_pkg::*;

  run_t             entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign full       = (count == QCntW'(QDepth));
  assign head_valid = (count != '0);
  assign head_run   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/u8sd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_back
// Unrolls each queued run into single results, one per cycle when not
// stalled by out_stall, into the output register.
// ----------------------------------------------------------------------------
module u8sd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  u8sd_pkg::run_t         head_run,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [u8sd_pkg::CpW-1:0] code_point,
  output logic                   last_of_run
);
  import u8sd_pkg::*;

  logic [1:0] idx;
  logic [2:0] total;
  logic       load_ok;
  logic       emit;
  logic       is_last;

  assign total   = {1'b0, head_run.n_rep} + {2'b00, head_run.tail_valid};
  assign load_ok = !out_valid || !out_stall;
  assign emit    = head_valid && load_ok;
  assign is_last = (({1'b0, idx} + 3'd1) == total);
  assign pop     = emit && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load_ok) begin
        out_valid <= emit;
      end
      if (emit) begin
        idx <= is_last ? 2'd0 : (idx + 2'd1);
      end
    end
  end

  // payload only
  always_ff @(posedge clk) begin
    if (emit) begin
      code_point  <= (idx < head_run.n_rep) ? ReplacementCp : head_run.tail_cp;
      last_of_run <= is_last;
    end
  end

endmodule

### rtl/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder: one byte in, zero to four code points out.
//
//   channel  handshake           payload
//   input    in_valid/in_stall   in_byte[7:0]
//   output   out_valid/out_stall code_point[20:0], last_of_run
//
// A byte is taken every cycle while the run queue has room; the front
// updates the sequence state in the cycle of the transfer.
// The back emits one result per cycle while out_stall is low; the four-entry
// run queue absorbs short error bursts. Results pass through the run queue
// and then the output register. Synchronous reset clears the sequence
// state, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [u8sd_pkg::CpW-1:0] code_point,
  output logic                     last_of_run
);
  import u8sd_pkg::*;

  logic accept;
  logic push;
  run_t push_run;
  logic q_full;
  logic pop;
  logic head_valid;
  run_t head_run;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  u8sd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .push     (push),
    .push_run (push_run)
  );

  u8sd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_run   (push_run),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_run   (head_run)
  );

  u8sd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_run    (head_run),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .last_of_run (last_of_run)
  );

endmodule
